[rtl/first_fit_bitmap_allocator_core_defines.svh]
// Assertion macros for the first-fit bitmap allocator.
`ifndef FIRST_FIT_BITMAP_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_BITMAP_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define FFBA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define FFBA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ffba_pkg.sv]
// Shared types and constants for the first-fit bitmap allocator.
package ffba_pkg;

   localparam int POOL_UNITS_DEF  = 256;
   localparam int MAX_RECORDS_DEF = 16;

   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_USER_W = 3;
   localparam int SIZE_W     = 9;
   localparam int FSTART_W   = 8;

   typedef enum logic [0:0] {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NO_RUN     = 3'd1,
      ST_NOT_FOUND  = 3'd2,
      ST_ZERO_SIZE  = 3'd3,
      ST_TABLE_FULL = 3'd4
   } status_type;

   typedef enum logic [8:0] {
      S_CLEAR  = 9'b000000001,
      S_IDLE   = 9'b000000010,
      S_SCAN   = 9'b000000100,
      S_FILL   = 9'b000001000,
      S_LK_RD  = 9'b000010000,
      S_LK_CMP = 9'b000100000,
      S_SH_RD  = 9'b001000000,
      S_SH_WR  = 9'b010000000,
      S_REPLY  = 9'b100000000
   } state_type;

endpackage

[rtl/ffba_ram.sv]
// Generic simple dual-port RAM with registered read.
module ffba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/first_fit_bitmap_allocator_core.sv]
// First-fit bitmap allocator top level: sequencer, busy map and record table.
//
// Allocates and frees runs of units in a pool of POOL_UNITS units, keeping up to
// MAX_RECORDS live allocations. After reset the block clears the busy map unit by
// unit and accepts no request until that pass ends. Requests are handled one at a
// time; the busy map is a one-port-per-side memory read one unit per cycle. An
// allocate scans the map from unit 0 for a free run of the size, then marks each
// granted unit busy and replies. A free reads and compares the records in order
// until one matches, then moves each later record down, closes the table,
// releases each of its units and replies. Rejected requests (zero size, full
// table, size beyond the pool, empty table) go straight to the reply. A request
// may be accepted while the previous result still waits on the response side.
module first_fit_bitmap_allocator_core #(
   parameter int POOL_UNITS  = ffba_pkg::POOL_UNITS_DEF,
   parameter int MAX_RECORDS = ffba_pkg::MAX_RECORDS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [8:0] request_size, [16:9] free_start, [23:17] zero
   input  logic [ffba_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] action
   input  logic [ffba_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] run_start
   output logic [ffba_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [2:0] status
   output logic [ffba_pkg::RSP_USER_W-1:0] rsp_tuser
);

   import ffba_pkg::*;

   localparam int PW = $clog2(POOL_UNITS);
   localparam int RW = $clog2(MAX_RECORDS);
   localparam int CW = $clog2(MAX_RECORDS + 1);
   localparam int LW = (PW > FSTART_W) ? PW : FSTART_W;
   localparam int AW = ((PW > SIZE_W) ? PW : SIZE_W) + 1;
   localparam int RECW = PW + SIZE_W;
   localparam logic [PW-1:0] LAST_UNIT = PW'(POOL_UNITS - 1);

   state_type           state_ff, state_in;
   logic [PW-1:0]       fill_addr_ff, fill_addr_in;
   logic [SIZE_W-1:0]   fill_left_ff, fill_left_in;
   logic                fill_val_ff, fill_val_in;
   logic [PW-1:0]       scan_addr_ff, scan_addr_in;
   logic                issue_ff, issue_in;
   logic                chk_valid_ff, chk_valid_in;
   logic [PW-1:0]       chk_addr_ff, chk_addr_in;
   logic [SIZE_W-1:0]   run_ff, run_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [FSTART_W-1:0] fstart_ff, fstart_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [RW-1:0]       idx_ff, idx_in;
   status_type          res_status_ff, res_status_in;
   logic [7:0]          res_start_ff, res_start_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [7:0]          rsp_start_ff, rsp_start_in;

   logic                req_fire;
   logic                req_action;
   logic [SIZE_W-1:0]   req_size;
   logic [FSTART_W-1:0] req_fstart;
   logic                alloc_full_hit;

   logic                map_wr_en;
   logic                map_wr_data;
   logic                map_rd_data;
   logic                rec_wr_en;
   logic [RW-1:0]       rec_wr_addr;
   logic [RECW-1:0]     rec_wr_data;
   logic [RW-1:0]       rec_rd_addr;
   logic [RECW-1:0]     rec_rd_data;
   logic [PW-1:0]       rec_start;
   logic [SIZE_W-1:0]   rec_size;

   logic [SIZE_W-1:0]   run_next;
   logic [AW-1:0]       first_wide;
   logic [PW-1:0]       first_unit;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_action = req_tuser[0];
   assign req_size   = req_tdata[SIZE_W-1:0];
   assign req_fstart = req_tdata[SIZE_W+FSTART_W-1:SIZE_W];

   assign alloc_full_hit = req_fire && (req_action == ACT_ALLOC) && (req_size != '0)
                           && (count_ff == CW'(MAX_RECORDS));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_start_ff;
   assign rsp_tuser  = rsp_status_ff;

   assign rec_start  = rec_rd_data[RECW-1:SIZE_W];
   assign rec_size   = rec_rd_data[SIZE_W-1:0];

   assign run_next   = map_rd_data ? '0 : run_ff + 1'b1;
   assign first_wide = AW'(chk_addr_ff) + AW'(1) - AW'(size_ff);
   assign first_unit = first_wide[PW-1:0];

   assign map_wr_en   = (state_ff == S_CLEAR) || (state_ff == S_FILL);
   assign map_wr_data = (state_ff == S_FILL) ? fill_val_ff : 1'b0;
   assign rec_rd_addr = (state_ff == S_SH_RD) ? idx_ff + 1'b1 : idx_ff;
   assign rec_wr_addr = (state_ff == S_SCAN) ? count_ff[RW-1:0] : idx_ff;

   ffba_ram #(
      .WIDTH (1),
      .DEPTH (POOL_UNITS)
   ) u_busy_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (fill_addr_ff),
      .wr_data (map_wr_data),
      .rd_addr (scan_addr_ff),
      .rd_data (map_rd_data)
   );

   ffba_ram #(
      .WIDTH (RECW),
      .DEPTH (MAX_RECORDS)
   ) u_records (
      .clock   (clock),
      .wr_en   (rec_wr_en),
      .wr_addr (rec_wr_addr),
      .wr_data (rec_wr_data),
      .rd_addr (rec_rd_addr),
      .rd_data (rec_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      fill_addr_in  = fill_addr_ff;
      fill_left_in  = fill_left_ff;
      fill_val_in   = fill_val_ff;
      scan_addr_in  = scan_addr_ff;
      issue_in      = issue_ff;
      chk_valid_in  = 1'b0;
      chk_addr_in   = chk_addr_ff;
      run_in        = run_ff;
      size_in       = size_ff;
      fstart_in     = fstart_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rec_wr_en     = 1'b0;
      rec_wr_data   = rec_rd_data;

      case (state_ff)
         S_CLEAR: begin
            fill_addr_in = fill_addr_ff + 1'b1;
            if (fill_addr_ff == LAST_UNIT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               size_in      = req_size;
               fstart_in    = req_fstart;
               res_start_in = '0;
               state_in     = S_REPLY;
               if (req_action == ACT_ALLOC) begin
                  if (req_size == '0) begin
                     res_status_in = ST_ZERO_SIZE;
                  end else if (count_ff == CW'(MAX_RECORDS)) begin
                     res_status_in = ST_TABLE_FULL;
                  end else if (32'(req_size) > 32'(POOL_UNITS)) begin
                     res_status_in = ST_NO_RUN;
                  end else begin
                     scan_addr_in = '0;
                     issue_in     = 1'b1;
                     run_in       = '0;
                     state_in     = S_SCAN;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_status_in = ST_NOT_FOUND;
                  end else begin
                     idx_in   = '0;
                     state_in = S_LK_RD;
                  end
               end
            end
         end
         S_SCAN: begin
            if (issue_ff) begin
               chk_valid_in = 1'b1;
               chk_addr_in  = scan_addr_ff;
               if (scan_addr_ff == LAST_UNIT) begin
                  issue_in = 1'b0;
               end else begin
                  scan_addr_in = scan_addr_ff + 1'b1;
               end
            end
            if (chk_valid_ff) begin
               run_in = run_next;
               if (run_next == size_ff) begin
                  rec_wr_en     = 1'b1;
                  rec_wr_data   = {first_unit, size_ff};
                  count_in      = count_ff + 1'b1;
                  fill_addr_in  = first_unit;
                  fill_left_in  = size_ff;
                  fill_val_in   = 1'b1;
                  res_status_in = ST_OK;
                  res_start_in  = 8'(first_unit);
                  state_in      = S_FILL;
               end else if (chk_addr_ff == LAST_UNIT) begin
                  res_status_in = ST_NO_RUN;
                  state_in      = S_REPLY;
               end
            end
         end
         S_FILL: begin
            fill_addr_in = fill_addr_ff + 1'b1;
            fill_left_in = fill_left_ff - 1'b1;
            if (fill_left_ff == SIZE_W'(1)) begin
               state_in = S_REPLY;
            end
         end
         S_LK_RD: begin
            state_in = S_LK_CMP;
         end
         S_LK_CMP: begin
            if (LW'(rec_start) == LW'(fstart_ff)) begin
               fill_addr_in  = rec_start;
               fill_left_in  = rec_size;
               fill_val_in   = 1'b0;
               res_status_in = ST_OK;
               state_in      = S_SH_RD;
            end else if (CW'(idx_ff) + CW'(1) == count_ff) begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_REPLY;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_LK_RD;
            end
         end
         S_SH_RD: begin
            if (CW'(idx_ff) + CW'(1) >= count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_FILL;
            end else begin
               state_in = S_SH_WR;
            end
         end
         S_SH_WR: begin
            rec_wr_en   = 1'b1;
            rec_wr_data = rec_rd_data;
            idx_in      = idx_ff + 1'b1;
            state_in    = S_SH_RD;
         end
         S_REPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = res_start_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         fill_addr_ff <= '0;
         issue_ff     <= 1'b0;
         chk_valid_ff <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_addr_ff <= fill_addr_in;
         issue_ff     <= issue_in;
         chk_valid_ff <= chk_valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_left_ff  <= fill_left_in;
      fill_val_ff   <= fill_val_in;
      scan_addr_ff  <= scan_addr_in;
      chk_addr_ff   <= chk_addr_in;
      run_ff        <= run_in;
      size_ff       <= size_in;
      fstart_ff     <= fstart_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
   end

`include "first_fit_bitmap_allocator_core_defines.svh"

   `FFBA_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CW'(MAX_RECORDS), "record count overflow")
   `FFBA_ASSERT_NXT(a_full_count, alloc_full_hit, $stable(count_ff), "full table count moved")
   `FFBA_ASSERT_IMP(a_run_below_size, state_ff == S_SCAN, run_ff < size_ff, "run overran size")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the first-fit bitmap allocator.
`timescale 1ns / 1ps

module tb_top;
   import ffba_pkg::*;

   localparam int RANDOM_ITEMS = 1822;
   localparam int HOLD_CYCLES  = 2000;
   localparam int DRAIN_CYCLES = 4 * POOL_UNITS_DEF;
   localparam int LIMIT_CYCLES = 10_000_000;
   localparam int PAD_W        = REQ_DATA_W - SIZE_W - FSTART_W;

   typedef struct packed {
      action_type          act;
      logic [SIZE_W-1:0]   size;
      logic [FSTART_W-1:0] fstart;
   } alloc_req_type;

   typedef struct packed {
      status_type status;
      logic [7:0] start;
   } alloc_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   alloc_req_type pending_req[$];
   alloc_rsp_type expected_rsp[$];
   alloc_req_type offered;

   logic [POOL_UNITS_DEF-1:0] unit_busy = '0;
   int rec_start[MAX_RECORDS_DEF];
   int rec_len[MAX_RECORDS_DEF];
   int rec_count = 0;

   int send_idle_pct = 29;
   int recv_idle_pct = 79;
   int hold_req_cnt = 0;
   int hold_ack_cnt = 0;
   int hold_left = 0;
   int accepted_count = 0;
   int result_count = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int status_seen[5] = '{default: 0};

   first_fit_bitmap_allocator_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic alloc_rsp_type predict_outcome(alloc_req_type r);
      alloc_rsp_type res;
      int run;
      int first;
      int hit;
      int u;
      int k;
      res.status = ST_OK;
      res.start  = '0;
      if (r.act == ACT_ALLOC) begin
         if (r.size == 0) begin
            res.status = ST_ZERO_SIZE;
         end else if (rec_count >= MAX_RECORDS_DEF) begin
            res.status = ST_TABLE_FULL;
         end else begin
            run = 0;
            first = -1;
            for (u = 0; u < POOL_UNITS_DEF; u++) begin
               if (first < 0) begin
                  run = unit_busy[u] ? 0 : run + 1;
                  if (run >= int'(r.size)) first = u + 1 - run;
               end
            end
            if (first < 0) begin
               res.status = ST_NO_RUN;
            end else begin
               for (k = first; k < first + int'(r.size) && k < POOL_UNITS_DEF; k++)
                  unit_busy[k] = 1'b1;
               rec_start[rec_count] = first;
               rec_len[rec_count] = int'(r.size);
               rec_count++;
               res.start = 8'(first);
            end
         end
      end else begin
         hit = -1;
         for (u = 0; u < rec_count; u++)
            if (hit < 0 && rec_start[u] == int'(r.fstart)) hit = u;
         if (hit < 0) begin
            res.status = ST_NOT_FOUND;
         end else begin
            for (k = rec_start[hit]; k < rec_start[hit] + rec_len[hit] && k < POOL_UNITS_DEF; k++)
               unit_busy[k] = 1'b0;
            for (u = hit; u + 1 < rec_count; u++) begin
               rec_start[u] = rec_start[u + 1];
               rec_len[u] = rec_len[u + 1];
            end
            rec_count--;
         end
      end
      return res;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("%0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic queue_request(input action_type act, input int size, input int fstart);
      alloc_req_type r;
      r.act = act;
      r.size = SIZE_W'(size);
      r.fstart = FSTART_W'(fstart);
      while (pending_req.size() >= 2) @(negedge clock);
      pending_req.push_back(r);
   endtask

   task automatic wait_all_done();
      @(negedge clock);
      while (pending_req.size() != 0 || req_tvalid || expected_rsp.size() != 0)
         @(negedge clock);
   endtask

   task automatic queue_random_request();
      int pick;
      int size;
      pick = $urandom_range(99);
      if (pick < 5) size = 0;
      else if (pick < 10) size = $urandom_range(511, 257);
      else if (pick < 22) size = $urandom_range(256, 17);
      else size = $urandom_range(16, 1);
      pick = $urandom_range(99);
      if (pick < 48)
         queue_request(ACT_ALLOC, size, $urandom_range(255));
      else if (pick < 90 && rec_count > 0)
         queue_request(ACT_FREE, $urandom_range(511),
                       rec_start[$urandom_range(rec_count - 1)]);
      else
         queue_request(ACT_FREE, $urandom_range(511), $urandom_range(255));
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rsp.push_back(predict_outcome(offered));
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered = pending_req.pop_front();
               req_tdata <= {{PAD_W{1'b0}}, offered.fstart, offered.size};
               req_tuser <= offered.act;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      alloc_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (expected_rsp.size() == 0) begin
               flag_mismatch($sformatf("unexpected result status %0d start %0d",
                                       rsp_tuser, rsp_tdata));
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_tuser !== want.status)
                  flag_mismatch($sformatf("status %0d, want %0d", rsp_tuser, want.status));
               if (rsp_tdata !== want.start)
                  flag_mismatch($sformatf("run_start %0d, want %0d", rsp_tdata, want.start));
               status_seen[int'(want.status)]++;
            end
         end
         if (hold_req_cnt != hold_ack_cnt) begin
            hold_ack_cnt <= hold_req_cnt;
            hold_left <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("first_fit_bitmap_allocator_core: mismatch");
         $finish;
      end
   end

   initial begin
      int k;
      int i;
      @(negedge clock);
      while (reset) @(negedge clock);

      queue_request(ACT_FREE, 0, 255);
      queue_request(ACT_ALLOC, 0, 255);
      queue_request(ACT_ALLOC, 511, 0);
      queue_request(ACT_ALLOC, 257, 0);
      queue_request(ACT_ALLOC, 256, 0);
      queue_request(ACT_ALLOC, 1, 0);
      queue_request(ACT_FREE, 511, 0);
      for (k = 1; k <= MAX_RECORDS_DEF; k++)
         queue_request(ACT_ALLOC, k, 0);
      queue_request(ACT_ALLOC, 1, 0);
      queue_request(ACT_ALLOC, 0, 0);
      queue_request(ACT_FREE, 0, 10);
      queue_request(ACT_FREE, 0, 11);
      queue_request(ACT_FREE, 0, 255);
      wait_all_done();

      hold_req_cnt++;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3) begin
            wait_all_done();
            send_idle_pct = 79;
            recv_idle_pct = 29;
         end
         if (i == 2 * RANDOM_ITEMS / 3) begin
            wait_all_done();
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         queue_random_request();
      end
      wait_all_done();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("%0d requests, %0d results in %0d cycles", accepted_count, result_count,
               cycle_count);
      $display("ok %0d, no run %0d, not found %0d, zero size %0d, table full %0d",
               status_seen[ST_OK], status_seen[ST_NO_RUN], status_seen[ST_NOT_FOUND],
               status_seen[ST_ZERO_SIZE], status_seen[ST_TABLE_FULL]);
      if (mismatch_count == 0 && expected_rsp.size() == 0) begin
         $display("first_fit_bitmap_allocator_core: match");
      end else begin
         $display("first_fit_bitmap_allocator_core: mismatch");
      end
      $finish;
   end

endmodule
